/* rtl/vspd_pkg.sv */
// Shared constants, codes and types of the video-over-SPI packet deframer.
package vspd_pkg;

  // Frame geometry.
  localparam int LINE_PIXELS     = 80;
  localparam int SEGMENT_PACKETS = 60;
  localparam int TALL_SEGMENTS   = 4;
  localparam int CHECKED_PACKET  = 20;

  // Derived sizes.
  localparam int PACKET_WORDS = LINE_PIXELS + 2;
  localparam int POS_W        = $clog2(PACKET_WORDS);
  localparam int IDX_W        = $clog2(LINE_PIXELS);
  localparam int LINE_W       = $clog2(SEGMENT_PACKETS * TALL_SEGMENTS + 1);
  localparam int SEGLINE_W    = $clog2(SEGMENT_PACKETS);

  // Fixed field widths.
  localparam int WORD_W = 16;
  localparam int ADDR_W = 15;
  localparam int PID_W  = 12;
  localparam int SEG_W  = 3;

  // ID word layout.
  localparam logic [3:0] DISCARD_NIBBLE = 4'hF;

  // Operation codes.
  localparam logic OP_STREAM  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Configuration register indexes and bus sizes.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_TALL_FRAME = 3'd0;

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0] pixel_value;
    logic [ADDR_W-1:0] buffer_address;
    logic              frame_complete;
    logic              sync_lost;
  } vspd_result_t;

endpackage

/* rtl/vspd_skid.sv */
// Two-entry output buffer: result register plus skid register.
module vspd_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  vspd_pkg::vspd_result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vspd_pkg::vspd_result_t out_data
);

  logic                  skid_valid;
  vspd_pkg::vspd_result_t skid_data;

  // The upstream side may hand over a result whenever the skid entry is free.
  assign space = !skid_valid;

  // Refill the output register when it is empty or being taken; else park in skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

/* rtl/video_spi_packet_deframer.sv */
// Top level of the video-over-SPI packet deframer.
//
// Usage: the input channel (in_valid/in_ready, operation, data_word) carries
// one 16-bit stream word or a restart command per transaction. Each packet is
// an ID word, a CRC word and 80 pixel words; pixels of accepted lines leave on
// the output channel (out_valid/out_ready) with their frame buffer address.
// A packet number mismatch after the first good line, or a segment mismatch
// after the first segment, gives one transaction with sync_lost set; stream
// words are then ignored until a restart. Results leave from a register.
// Throughput is one input transaction per cycle, set by the single register
// stage that holds the deframing state; each word needs only compares and
// counter updates. The output register plus a skid register keep input
// accepted while a result waits; input stalls only once both are full.
// After reset the block waits for a restart command before taking words, and
// tall_frame is 0. The APB port holds tall_frame at address 0, which the user
// must have written only while the block is idle; the block does not enforce it.
module video_spi_packet_deframer (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vspd_pkg::PADDR_W-1:0]    paddr,
  input  logic [vspd_pkg::PDATA_W-1:0]    pwdata,
  output logic [vspd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [vspd_pkg::WORD_W-1:0]     data_word,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vspd_pkg::WORD_W-1:0]     pixel_value,
  output logic [vspd_pkg::ADDR_W-1:0]     buffer_address,
  output logic                            frame_complete,
  output logic                            sync_lost
);

  // Deframing state.
  logic                             tall_frame;
  logic [vspd_pkg::POS_W-1:0]       word_position, word_position_next;
  logic                             packet_accepted, packet_accepted_next;
  logic [vspd_pkg::LINE_W-1:0]      line_count, line_count_next;
  logic [vspd_pkg::SEGLINE_W-1:0]   segment_line, segment_line_next;
  logic [vspd_pkg::ADDR_W-1:0]      line_base, line_base_next;
  logic [vspd_pkg::SEG_W-1:0]       expected_segment, expected_segment_next;
  logic                             resync_needed, resync_needed_next;

  logic                             in_fire;
  logic                             res_valid;
  vspd_pkg::vspd_result_t           res;
  vspd_pkg::vspd_result_t           out_data;

  logic [vspd_pkg::LINE_W-1:0]      frame_total;
  logic                             frame_full;
  logic [vspd_pkg::PID_W-1:0]       pid;
  logic [vspd_pkg::SEG_W-1:0]       seg;
  logic [vspd_pkg::IDX_W-1:0]       pixel_idx;
  logic                             pid_bad;
  logic                             seg_bad;

  // APB register access.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_frame <= 1'b0;
    end else if (psel && penable && pwrite && paddr == vspd_pkg::REG_TALL_FRAME) begin
      tall_frame <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == vspd_pkg::REG_TALL_FRAME) begin
      prdata[0] = tall_frame;
    end
  end

  assign in_fire = in_valid && in_ready;

  // Header fields and frame limits.
  assign frame_total = tall_frame
                     ? vspd_pkg::LINE_W'(vspd_pkg::SEGMENT_PACKETS * vspd_pkg::TALL_SEGMENTS)
                     : vspd_pkg::LINE_W'(vspd_pkg::SEGMENT_PACKETS);
  assign frame_full  = line_count >= frame_total;
  assign pid         = data_word[vspd_pkg::PID_W-1:0];
  assign seg         = data_word[14:12];
  assign pixel_idx   = vspd_pkg::IDX_W'(word_position - vspd_pkg::POS_W'(2));
  assign pid_bad     = pid != vspd_pkg::PID_W'(segment_line);
  assign seg_bad     = tall_frame && pid == vspd_pkg::PID_W'(vspd_pkg::CHECKED_PACKET)
                       && seg != expected_segment;

  // Per-word deframing decision.
  always_comb begin
    word_position_next    = word_position;
    packet_accepted_next  = packet_accepted;
    line_count_next       = line_count;
    segment_line_next     = segment_line;
    line_base_next        = line_base;
    expected_segment_next = expected_segment;
    resync_needed_next    = resync_needed;
    res_valid             = 1'b0;
    res                   = '0;

    if (operation == vspd_pkg::OP_RESTART) begin
      word_position_next    = '0;
      packet_accepted_next  = 1'b0;
      line_count_next       = '0;
      segment_line_next     = '0;
      line_base_next        = '0;
      expected_segment_next = vspd_pkg::SEG_W'(1);
      resync_needed_next    = 1'b0;
    end else if (!resync_needed) begin
      word_position_next = (word_position == vspd_pkg::POS_W'(vspd_pkg::PACKET_WORDS - 1))
                         ? '0 : word_position + vspd_pkg::POS_W'(1);

      if (word_position == '0) begin
        // ID word: decide whether this packet's pixels are kept.
        packet_accepted_next = 1'b0;
        if (!frame_full && data_word[11:8] != vspd_pkg::DISCARD_NIBBLE) begin
          if (pid_bad || seg_bad) begin
            if ((pid_bad && line_count == '0) ||
                (!pid_bad && expected_segment == vspd_pkg::SEG_W'(1))) begin
              // Mismatch before the frame is under way: quietly wait again.
              line_count_next       = '0;
              segment_line_next     = '0;
              line_base_next        = '0;
              expected_segment_next = vspd_pkg::SEG_W'(1);
            end else begin
              resync_needed_next = 1'b1;
              res_valid          = 1'b1;
              res.sync_lost      = 1'b1;
            end
          end else begin
            packet_accepted_next = 1'b1;
          end
        end
      end else if (word_position != vspd_pkg::POS_W'(1) && packet_accepted) begin
        // Pixel word of an accepted line.
        res_valid          = 1'b1;
        res.pixel_value    = data_word;
        res.buffer_address = line_base + vspd_pkg::ADDR_W'(pixel_idx);
        if (pixel_idx == vspd_pkg::IDX_W'(vspd_pkg::LINE_PIXELS - 1)) begin
          line_count_next      = line_count + vspd_pkg::LINE_W'(1);
          line_base_next       = line_base + vspd_pkg::ADDR_W'(vspd_pkg::LINE_PIXELS);
          packet_accepted_next = 1'b0;
          if (segment_line == vspd_pkg::SEGLINE_W'(vspd_pkg::SEGMENT_PACKETS - 1)) begin
            segment_line_next     = '0;
            expected_segment_next = expected_segment + vspd_pkg::SEG_W'(1);
          end else begin
            segment_line_next = segment_line + vspd_pkg::SEGLINE_W'(1);
          end
          res.frame_complete = (line_count + vspd_pkg::LINE_W'(1)) == frame_total;
        end
      end
    end
  end

  // State register, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      packet_accepted  <= 1'b0;
      line_count       <= '0;
      segment_line     <= '0;
      line_base        <= '0;
      expected_segment <= vspd_pkg::SEG_W'(1);
      resync_needed    <= 1'b1;
    end else if (in_fire) begin
      word_position    <= word_position_next;
      packet_accepted  <= packet_accepted_next;
      line_count       <= line_count_next;
      segment_line     <= segment_line_next;
      line_base        <= line_base_next;
      expected_segment <= expected_segment_next;
      resync_needed    <= resync_needed_next;
    end
  end

  // Result register with skid entry.
  vspd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign pixel_value    = out_data.pixel_value;
  assign buffer_address = out_data.buffer_address;
  assign frame_complete = out_data.frame_complete;
  assign sync_lost      = out_data.sync_lost;

endmodule

/* tb/sv/video_spi_packet_deframer_checker.sv */
// Result predictor and comparator for the video-over-SPI packet deframer.
`timescale 1ns / 1ps
module video_spi_packet_deframer_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vspd_pkg::PADDR_W-1:0] paddr,
  input  logic [vspd_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         operation,
  input  logic [vspd_pkg::WORD_W-1:0]  data_word,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [vspd_pkg::WORD_W-1:0]  pixel_value,
  input  logic [vspd_pkg::ADDR_W-1:0]  buffer_address,
  input  logic                         frame_complete,
  input  logic                         sync_lost,
  output int                           outstanding,
  output int                           fail_count
);

  // Shadow of the configuration and of the deframing state.
  logic                   tall_mode;
  logic [6:0]             word_pos;
  logic                   line_open;
  logic [7:0]             lines_done;
  logic [2:0]             want_segment;
  logic                   awaiting_restart;
  vspd_pkg::vspd_result_t due_pixels[$];
  int                     fails = 0;

  // Lines in one frame for the current mode.
  function automatic int frame_lines();
    return tall_mode ? vspd_pkg::SEGMENT_PACKETS * vspd_pkg::TALL_SEGMENTS
                     : vspd_pkg::SEGMENT_PACKETS;
  endfunction

  // Advances the shadow state by one input transaction; returns 1 when it yields a result.
  function automatic bit deframe_word(input logic op, input logic [vspd_pkg::WORD_W-1:0] w,
                                      output vspd_pkg::vspd_result_t r);
    int          pos;
    logic [11:0] pid;
    r = '0;
    if (op == vspd_pkg::OP_RESTART) begin
      word_pos         = '0;
      line_open        = 1'b0;
      lines_done       = '0;
      want_segment     = 3'd1;
      awaiting_restart = 1'b0;
      return 1'b0;
    end
    if (awaiting_restart)
      return 1'b0;

    pos      = int'(word_pos);
    word_pos = (pos + 1 >= vspd_pkg::PACKET_WORDS) ? 7'd0 : 7'(pos + 1);

    // ID word: discard, frame full, packet number and segment checks.
    if (pos == 0) begin
      pid       = w[vspd_pkg::PID_W-1:0];
      line_open = 1'b0;
      if (lines_done >= frame_lines() || w[11:8] == vspd_pkg::DISCARD_NIBBLE)
        return 1'b0;
      if (pid != lines_done % vspd_pkg::SEGMENT_PACKETS) begin
        if (lines_done == 0) begin
          want_segment = 3'd1;
          return 1'b0;
        end
        awaiting_restart = 1'b1;
        r.sync_lost      = 1'b1;
        return 1'b1;
      end
      if (tall_mode && pid == vspd_pkg::CHECKED_PACKET && w[14:12] != want_segment) begin
        if (want_segment == 3'd1) begin
          lines_done = '0;
          return 1'b0;
        end
        awaiting_restart = 1'b1;
        r.sync_lost      = 1'b1;
        return 1'b1;
      end
      line_open = 1'b1;
      return 1'b0;
    end
    if (pos == 1 || !line_open)
      return 1'b0;

    // Pixel word of an accepted line.
    r.pixel_value    = w;
    r.buffer_address = vspd_pkg::ADDR_W'(lines_done * vspd_pkg::LINE_PIXELS + pos - 2);
    if (pos - 2 == vspd_pkg::LINE_PIXELS - 1) begin
      lines_done = lines_done + 8'd1;
      line_open  = 1'b0;
      if (lines_done % vspd_pkg::SEGMENT_PACKETS == 0)
        want_segment = want_segment + 3'd1;
      if (lines_done == frame_lines())
        r.frame_complete = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      fails++;
    end
  endtask

  // Compare delivered results first, then queue what the new input transaction yields.
  always @(posedge clk) begin
    vspd_pkg::vspd_result_t want;
    vspd_pkg::vspd_result_t fresh;
    if (rst) begin
      tall_mode        = 1'b0;
      word_pos         = '0;
      line_open        = 1'b0;
      lines_done       = '0;
      want_segment     = 3'd1;
      awaiting_restart = 1'b1;
      due_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == vspd_pkg::REG_TALL_FRAME)
        tall_mode = pwdata[0];
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: result with none expected, got pixel %0h address %0h done %b lost %b",
                   $time, pixel_value, buffer_address, frame_complete, sync_lost);
          fails++;
        end else begin
          want = due_pixels.pop_front();
          check_field("pixel_value", 32'(want.pixel_value), 32'(pixel_value));
          check_field("buffer_address", 32'(want.buffer_address), 32'(buffer_address));
          check_field("frame_complete", 32'(want.frame_complete), 32'(frame_complete));
          check_field("sync_lost", 32'(want.sync_lost), 32'(sync_lost));
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_word(operation, data_word, fresh))
          due_pixels.push_back(fresh);
      end
    end
    outstanding <= due_pixels.size();
    fail_count  <= fails;
  end

endmodule

/* tb/sv/video_spi_packet_deframer_test.sv */
// Stimulus and verdict for the video-over-SPI packet deframer testbench.
`timescale 1ns / 1ps
module video_spi_packet_deframer_test;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [vspd_pkg::PADDR_W-1:0] paddr;
  logic [vspd_pkg::PDATA_W-1:0] pwdata;
  logic [vspd_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_ready;
  logic                         operation;
  logic [vspd_pkg::WORD_W-1:0]  data_word;
  logic                         out_valid;
  logic                         out_ready;
  logic [vspd_pkg::WORD_W-1:0]  pixel_value;
  logic [vspd_pkg::ADDR_W-1:0]  buffer_address;
  logic                         frame_complete;
  logic                         sync_lost;
  int                           outstanding;
  int                           fail_count;

  // Stream generator state: the line the next good packet carries, and the mode.
  int                           gen_line;
  logic                         tall;
  int                           in_gap_max;
  int                           out_gap_max;

  video_spi_packet_deframer DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_value(pixel_value),
    .buffer_address(buffer_address), .frame_complete(frame_complete), .sync_lost(sync_lost)
  );

  video_spi_packet_deframer_checker frame_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_value(pixel_value),
    .buffer_address(buffer_address), .frame_complete(frame_complete), .sync_lost(sync_lost),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Segment number that the current line belongs to.
  function automatic logic [2:0] segment_of_line();
    return 3'(1 + gen_line / vspd_pkg::SEGMENT_PACKETS);
  endfunction

  // Random pixel with extra weight on both extremes.
  function automatic logic [vspd_pkg::WORD_W-1:0] pixel_word();
    unique case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ID word that matches the expected line, with random spare bits.
  function automatic logic [vspd_pkg::WORD_W-1:0] good_header();
    logic [vspd_pkg::WORD_W-1:0] head;
    head       = 16'($urandom);
    head[11:0] = 12'(gen_line % vspd_pkg::SEGMENT_PACKETS);
    if (tall && gen_line % vspd_pkg::SEGMENT_PACKETS == vspd_pkg::CHECKED_PACKET)
      head[14:12] = segment_of_line();
    return head;
  endfunction

  // ID word of the checked packet with any segment number but the right one.
  function automatic logic [vspd_pkg::WORD_W-1:0] wrong_segment_header();
    logic [vspd_pkg::WORD_W-1:0] head;
    head        = 16'($urandom);
    head[11:0]  = 12'(vspd_pkg::CHECKED_PACKET);
    head[14:12] = segment_of_line() ^ 3'($urandom_range(1, 7));
    return head;
  endfunction

  // One input transaction after a random gap.
  task automatic send_item(input logic op, input logic [vspd_pkg::WORD_W-1:0] word);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_word <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // A whole packet: the given ID word, a CRC word and a line of pixels.
  task automatic send_packet(input logic [vspd_pkg::WORD_W-1:0] head);
    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    send_item(vspd_pkg::OP_STREAM, head);
    repeat (vspd_pkg::PACKET_WORDS - 1) send_item(vspd_pkg::OP_STREAM, pixel_word());
  endtask

  task automatic restart_capture();
    send_item(vspd_pkg::OP_RESTART, 16'($urandom));
    gen_line = 0;
  endtask

  // After a lost sync a few words are ignored before the restart.
  task automatic regain_sync();
    repeat ($urandom_range(1, 4)) send_item(vspd_pkg::OP_STREAM, pixel_word());
    restart_capture();
  endtask

  // Register write once the block has delivered everything it owes.
  task automatic set_tall(input logic value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= vspd_pkg::REG_TALL_FRAME;
    pwdata  <= {31'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tall = value;
  endtask

  // Good lines up to a target, with discard packets and, at a given rate, faults.
  task automatic run_lines(input int target, input int fault_pct, input int budget);
    int                          roll;
    int                          kind;
    int                          pid;
    logic [vspd_pkg::WORD_W-1:0] head;
    while (gen_line < target && budget > 0) begin
      budget--;
      roll = $urandom_range(0, 99);
      if (roll < fault_pct) begin
        kind = $urandom_range(0, 3);
        if (tall && gen_line % vspd_pkg::SEGMENT_PACKETS == vspd_pkg::CHECKED_PACKET
            && kind < 2) begin
          // Wrong segment: silent in the first segment, lost sync later.
          send_packet(wrong_segment_header());
          if (segment_of_line() == 3'd1)
            gen_line = 0;
          else
            regain_sync();
        end else if (kind < 2) begin
          // Wrong packet number; the discard nibble is kept out.
          head = 16'($urandom);
          pid  = $urandom_range(0, 'hEFF);
          if (pid == gen_line % vspd_pkg::SEGMENT_PACKETS)
            pid++;
          head[11:0] = 12'(pid);
          send_packet(head);
          if (gen_line > 0)
            regain_sync();
        end else if (kind == 2) begin
          // Restart in the middle of a line.
          send_item(vspd_pkg::OP_STREAM, good_header());
          repeat ($urandom_range(0, vspd_pkg::LINE_PIXELS))
            send_item(vspd_pkg::OP_STREAM, pixel_word());
          restart_capture();
        end else begin
          // Stray words shift the packet framing until the next restart.
          repeat ($urandom_range(1, 3)) send_item(vspd_pkg::OP_STREAM, pixel_word());
          send_packet(good_header());
          restart_capture();
        end
      end else if (roll < fault_pct + 5) begin
        send_packet({4'($urandom), vspd_pkg::DISCARD_NIBBLE, 8'($urandom)});
      end else begin
        send_packet(good_header());
        gen_line++;
      end
    end
  endtask

  // Output side: a random stall before each result is taken.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int spins;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = vspd_pkg::REG_TALL_FRAME;
    pwdata      = '0;
    in_valid    = 1'b0;
    operation   = vspd_pkg::OP_STREAM;
    data_word   = '0;
    gen_line    = 0;
    tall        = 1'b0;
    in_gap_max  = 5;
    out_gap_max = 5;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Words before the first restart are ignored.
    send_item(vspd_pkg::OP_STREAM, 16'h0000);
    send_item(vspd_pkg::OP_STREAM, 16'hFFFF);
    send_item(vspd_pkg::OP_RESTART, 16'hFFFF);
    gen_line = 0;
    // Discard packet, then a wrong packet number while no line is in yet.
    send_packet(16'h0F00);
    send_packet(16'h7007);
    // Line 0 with pixels at both extremes.
    send_item(vspd_pkg::OP_STREAM, 16'h8000);
    send_item(vspd_pkg::OP_STREAM, 16'hFFFF);
    send_item(vspd_pkg::OP_STREAM, 16'hFFFF);
    send_item(vspd_pkg::OP_STREAM, 16'h0000);
    repeat (vspd_pkg::LINE_PIXELS - 2) send_item(vspd_pkg::OP_STREAM, pixel_word());
    gen_line = 1;
    // Wrong packet number after a good line loses sync.
    send_packet(16'h0EFF);
    regain_sync();

    // A few good lines in normal mode.
    run_lines(3, 0, 4);

    // Short runs in random modes with frequent faults.
    repeat (2) begin
      set_tall(1'($urandom_range(0, 1)));
      restart_capture();
      run_lines($urandom_range(1, 2), 30, 2);
    end

    in_valid <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (outstanding != 0 && spins < 1000);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hard stop in case the block stops handshaking.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/vspd_pkg.sv
rtl/vspd_skid.sv
rtl/video_spi_packet_deframer.sv
tb/sv/video_spi_packet_deframer_checker.sv
tb/sv/video_spi_packet_deframer_test.sv
